>>> src/fil_pkg.sv
package fil_pkg;

  // Width of the shared divider and of the text length register.
  localparam int unsigned DIV_W  = 17;
  localparam int unsigned TLEN_W = 17;

  // Rank checkpoint spacing: one checkpoint row every BLK_LEN bytes of BWT.
  localparam int unsigned BLK_SHIFT = 6;
  localparam int unsigned BLK_LEN   = 1 << BLK_SHIFT;

  // Item commands.
  typedef enum logic [2:0] {
    CMD_LOAD_BWT    = 3'd0,
    CMD_LOAD_COUNT  = 3'd1,
    CMD_LOAD_CKPT   = 3'd2,
    CMD_LOAD_SAMPLE = 3'd3,
    CMD_LOCATE      = 3'd4
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_NOSAMPLE = 2'd2
  } status_e;

  // Write strobes from the command decoder to the table store.
  typedef struct packed {
    logic bwt_we;
    logic cnt_we;
    logic cp_we;
    logic smp_we;
  } mem_we_t;

endpackage

>>> src/fil_div.sv
module fil_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [fil_pkg::DIV_W-1:0] dividend_i,
  input  logic [fil_pkg::DIV_W-1:0] divisor_i,
  output logic                     done_o,
  output logic [fil_pkg::DIV_W-1:0] remainder_o
);
  import fil_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic             active_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] num_q;
  logic [DIV_W-1:0] rem_q;
  logic [DIV_W-1:0] div_q;
  logic [DIV_W:0]   trial;
  logic             fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial = {rem_q, num_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  // Control: count one bit per cycle and pulse done after the last one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= CNT_W'(DIV_W);
      end else if (active_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register shifts out as the quotient shifts in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (active_q) begin
      num_q <= {num_q[DIV_W-2:0], fits};
      rem_q <= fits ? DIV_W'(trial - {1'b0, div_q}) : DIV_W'(trial);
    end
  end

  assign done_o      = done_q;
  assign remainder_o = rem_q;

endmodule

>>> src/fil_mem.sv
module fil_mem #(
  parameter int unsigned MAX_LEN = 65536,
  parameter int unsigned ADDR_W  = $clog2(MAX_LEN),
  parameter int unsigned CPB     = (MAX_LEN + fil_pkg::BLK_LEN - 1) / fil_pkg::BLK_LEN,
  parameter int unsigned CPB_W   = (CPB > 1) ? $clog2(CPB) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fil_pkg::mem_we_t    we_i,
  input  logic [15:0]         wr_row_i,
  input  logic [7:0]          wr_sym_i,
  input  logic [9:0]          wr_blk_i,
  input  logic [16:0]         wr_val_i,
  input  logic [ADDR_W-1:0]   bwt_raddr_i,
  output logic [7:0]          bwt_rdata_o,
  input  logic [ADDR_W-1:0]   smp_raddr_i,
  output logic                smp_valid_o,
  output logic [15:0]         smp_pos_o,
  input  logic [7:0]          cnt_raddr_i,
  output logic [16:0]         cnt_rdata_o,
  input  logic [CPB_W+7:0]    cp_raddr_i,
  output logic [16:0]         cp_rdata_o,
  output logic                clearing_o
);
  import fil_pkg::*;

  logic [7:0]  bwt_mem [0:MAX_LEN-1];
  logic [16:0] smp_mem [0:MAX_LEN-1];
  logic [16:0] cnt_mem [0:255];
  logic [16:0] cp_mem  [0:CPB*256-1];

  logic              clearing_q;
  logic [ADDR_W-1:0] clr_q;
  logic              row_ok;
  logic              blk_ok;

  assign row_ok = 32'(wr_row_i) < MAX_LEN;
  assign blk_ok = 32'(wr_blk_i) < CPB;

  // Clearing pass over the sample valid bits after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == ADDR_W'(MAX_LEN - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // BWT byte store.
  always_ff @(posedge clk_i) begin
    if (we_i.bwt_we && row_ok) begin
      bwt_mem[ADDR_W'(wr_row_i)] <= wr_val_i[7:0];
    end
    bwt_rdata_o <= bwt_mem[bwt_raddr_i];
  end

  // Sampled suffix array: valid bit on top of the text position.
  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      smp_mem[clr_q] <= '0;
    end else if (we_i.smp_we && row_ok) begin
      smp_mem[ADDR_W'(wr_row_i)] <= {1'b1, wr_val_i[15:0]};
    end
    {smp_valid_o, smp_pos_o} <= smp_mem[smp_raddr_i];
  end

  // Cumulative count table.
  always_ff @(posedge clk_i) begin
    if (we_i.cnt_we) begin
      cnt_mem[wr_sym_i] <= wr_val_i;
    end
    cnt_rdata_o <= cnt_mem[cnt_raddr_i];
  end

  // Rank checkpoints, one row of 256 symbols per block.
  always_ff @(posedge clk_i) begin
    if (we_i.cp_we && blk_ok) begin
      cp_mem[{CPB_W'(wr_blk_i), wr_sym_i}] <= wr_val_i;
    end
    cp_rdata_o <= cp_mem[cp_raddr_i];
  end

  assign clearing_o = clearing_q;

endmodule

>>> src/fm_index_locate.sv
// FM-index locate engine. Load items (cmd 0 to 3) are written when accepted
// and do not raise busy. A locate item walks LF steps until it hits a sampled
// row, a row out of range or the WALK_LIMIT step limit. Each step runs a
// range check and a read of the row, the count and checkpoint lookups, then
// a byte-at-a-time rank scan over the BWT store's single read port from the
// block start. The row splits into block and offset by a shift and a mask.
// The final position (sample plus steps, modulo the length) takes one pass of
// the shared 17-bit serial divider after the check and read of the sampled
// row. A row out of range answers from the range check. After reset a
// clearing pass runs over the sample valid bits, with busy high; text_length
// may be written then, and otherwise only while busy is low. Each result is
// shown for exactly one cycle on done_o and cannot be stalled.
module fm_index_locate #(
  parameter int unsigned MAX_LEN    = 65536,
  parameter int unsigned WALK_LIMIT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd_i,
  input  logic [15:0] row_i,
  input  logic [7:0]  symbol_i,
  input  logic [9:0]  block_i,
  input  logic [16:0] value_i,
  output logic        done_o,
  output logic [15:0] position_o,
  output logic [5:0]  steps_o,
  output logic [1:0]  status_o
);
  import fil_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_LEN);
  localparam int unsigned CPB    = (MAX_LEN + BLK_LEN - 1) / BLK_LEN;
  localparam int unsigned CPB_W  = (CPB > 1) ? $clog2(CPB) : 1;
  localparam int unsigned OFF_W  = BLK_SHIFT;
  localparam int unsigned STEP_W = $clog2(WALK_LIMIT + 1);
  localparam int unsigned CUR_W  = 19;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_TBLRD = 3'd4;
  localparam logic [2:0] S_TBL   = 3'd5;
  localparam logic [2:0] S_SCAN  = 3'd6;
  localparam logic [2:0] S_MODW  = 3'd7;

  logic [2:0]        state_q;
  logic [TLEN_W-1:0] text_len_q;
  logic [CUR_W-1:0]  cur_q;
  logic [CUR_W-1:0]  start_q;
  logic [CUR_W-1:0]  acc_q;
  logic [STEP_W-1:0] steps_q;
  logic [7:0]        c_q;
  logic [CPB_W-1:0]  blk_q;
  logic [OFF_W-1:0]  off_q;
  logic [OFF_W-1:0]  k_q;
  logic              done_q;
  logic [15:0]       pos_q;
  logic [STEP_W-1:0] res_steps_q;
  logic [1:0]        res_sts_q;

  logic              accept;
  logic              clearing;
  mem_we_t           mem_we;
  logic [TLEN_W-1:0] len_w;
  logic              cur_in_range;
  logic [ADDR_W-1:0] bwt_raddr;
  logic [7:0]        bwt_rdata;
  logic              smp_valid;
  logic [15:0]       smp_pos;
  logic [16:0]       cnt_rdata;
  logic [16:0]       cp_rdata;
  logic              match;
  logic [CUR_W-1:0]  base;
  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [DIV_W-1:0]  div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  div_rem;

  assign busy   = clearing || (state_q != S_IDLE);
  assign accept = start && !busy;

  // Load decode.
  always_comb begin
    mem_we.bwt_we = accept && (cmd_i == CMD_LOAD_BWT);
    mem_we.cnt_we = accept && (cmd_i == CMD_LOAD_COUNT);
    mem_we.cp_we  = accept && (cmd_i == CMD_LOAD_CKPT);
    mem_we.smp_we = accept && (cmd_i == CMD_LOAD_SAMPLE);
  end

  // Length in use, clipped to the store size.
  assign len_w = (32'(text_len_q) > MAX_LEN) ? TLEN_W'(MAX_LEN) : text_len_q;
  assign cur_in_range = cur_q < CUR_W'(len_w);

  // BWT read address: the current row, the block start, or the next byte of the rank scan.
  always_comb begin
    case (state_q) inside
      S_TBLRD, S_TBL: bwt_raddr = ADDR_W'(start_q);
      S_SCAN:         bwt_raddr = ADDR_W'(start_q + CUR_W'(k_q) + CUR_W'(1));
      default:        bwt_raddr = ADDR_W'(cur_q);
    endcase
  end

  assign match = bwt_rdata == c_q;
  assign base  = CUR_W'(cnt_rdata) + ((cur_q == '0) ? '0 : CUR_W'(cp_rdata));

  // Shared divider: sampled position plus steps, modulo the length in use.
  assign div_start    = (state_q == S_RD) && smp_valid;
  assign div_dividend = DIV_W'(smp_pos) + DIV_W'(steps_q);
  assign div_divisor  = DIV_W'(len_w);

  fil_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .remainder_o (div_rem)
  );

  fil_mem #(
    .MAX_LEN (MAX_LEN)
  ) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .we_i        (mem_we),
    .wr_row_i    (row_i),
    .wr_sym_i    (symbol_i),
    .wr_blk_i    (block_i),
    .wr_val_i    (value_i),
    .bwt_raddr_i (bwt_raddr),
    .bwt_rdata_o (bwt_rdata),
    .smp_raddr_i (ADDR_W'(cur_q)),
    .smp_valid_o (smp_valid),
    .smp_pos_o   (smp_pos),
    .cnt_raddr_i (c_q),
    .cnt_rdata_o (cnt_rdata),
    .cp_raddr_i  ({blk_q, c_q}),
    .cp_rdata_o  (cp_rdata),
    .clearing_o  (clearing)
  );

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_len_q <= TLEN_W'(65536);
    end else if (cfg_we_i) begin
      text_len_q <= cfg_data_i;
    end
  end

  // Locate sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept && (cmd_i == CMD_LOCATE)) begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          if (!cur_in_range) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_RD;
          end
        end
        S_RD: begin
          if (smp_valid) begin
            state_q <= S_MODW;
          end else if (steps_q == STEP_W'(WALK_LIMIT)) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_TBLRD;
          end
        end
        S_TBLRD: state_q <= S_TBL;
        S_TBL: begin
          state_q <= (off_q == '0) ? S_CHK : S_SCAN;
        end
        S_SCAN: begin
          if ({1'b0, k_q} + 1'b1 == {1'b0, off_q}) begin
            state_q <= S_CHK;
          end
        end
        S_MODW: begin
          if (div_done) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Walk datapath and result registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cur_q   <= CUR_W'(row_i);
        steps_q <= '0;
      end
      S_CHK: begin
        if (!cur_in_range) begin
          pos_q       <= '0;
          res_steps_q <= steps_q;
          res_sts_q   <= ST_RANGE;
        end
      end
      S_RD: begin
        // Block and offset of the row come straight from its bits.
        c_q     <= bwt_rdata;
        blk_q   <= CPB_W'(cur_q >> BLK_SHIFT);
        off_q   <= cur_q[OFF_W-1:0];
        start_q <= cur_q & ~CUR_W'(BLK_LEN - 1);
        if (!smp_valid) begin
          pos_q       <= '0;
          res_steps_q <= steps_q;
          res_sts_q   <= ST_NOSAMPLE;
        end
      end
      S_TBL: begin
        acc_q <= base;
        k_q   <= '0;
        if (off_q == '0) begin
          cur_q   <= base;
          steps_q <= steps_q + 1'b1;
        end
      end
      S_SCAN: begin
        acc_q <= acc_q + CUR_W'(match);
        k_q   <= k_q + 1'b1;
        if ({1'b0, k_q} + 1'b1 == {1'b0, off_q}) begin
          cur_q   <= acc_q + CUR_W'(match);
          steps_q <= steps_q + 1'b1;
        end
      end
      S_MODW: begin
        pos_q       <= 16'(div_rem);
        res_steps_q <= steps_q;
        res_sts_q   <= ST_OK;
      end
      default: begin
      end
    endcase
  end

  assign done_o     = done_q;
  assign position_o = pos_q;
  assign steps_o    = 6'(res_steps_q);
  assign status_o   = res_sts_q;

  // A walk cut off by the step limit reports exactly the limit.
  a_limit_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_NOSAMPLE)) |-> (steps_o == 6'(WALK_LIMIT)))
    else $error("step limit result with wrong step count");

  // A failed locate reports position zero.
  a_fail_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (position_o == '0))
    else $error("failed locate with nonzero position");

  // An accepted locate keeps the block busy on the next cycle.
  a_locate_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == CMD_LOCATE)) |=> busy)
    else $error("locate accepted but block not busy");

  // A load never produces a result.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i != CMD_LOCATE)) |=> !done_o)
    else $error("result after a load item");

endmodule
